@@ rtl/core/socks5_handshake_parser_macros.svh @@
// Assertion macros shared by the parser modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SOCKS5_HANDSHAKE_PARSER_MACROS_SVH
`define SOCKS5_HANDSHAKE_PARSER_MACROS_SVH

// Same-cycle implication.
`define S5HP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define S5HP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/s5hp_pkg.sv @@
package s5hp_pkg;

	// Configured credential storage, in bytes
	parameter int CRED_BYTES = 20;
	parameter int CRED_IDX_W = $clog2(CRED_BYTES);

	// Longest name and password a client may send
	parameter logic [7:0] MAX_NAME_LEN = 8'd20;
	parameter logic [7:0] MAX_PASS_LEN = 8'd20;

	// Default depth of the result queue (at least two)
	parameter int OUTQ_DEPTH = 4;

	// Protocol bytes
	parameter logic [7:0] SOCKS_VER     = 8'h05;
	parameter logic [7:0] METH_USERPASS = 8'h02;
	parameter logic [7:0] METH_NONE     = 8'h00;
	parameter logic [7:0] AUTH_OK       = 8'h00;
	parameter logic [7:0] CMD_CONNECT   = 8'h01;
	parameter logic [7:0] ATYP_IPV4     = 8'h01;
	parameter logic [7:0] ATYP_DOMAIN   = 8'h03;
	parameter logic [7:0] ATYP_IPV6     = 8'h04;
	parameter logic [7:0] IPV4_LEN      = 8'd4;
	parameter logic [7:0] IPV6_LEN      = 8'd16;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_USER_LEN     = 3'd0,
		REG_PASS_LEN     = 3'd1,
		REG_USER_0_7     = 3'd2,
		REG_USER_8_15    = 3'd3,
		REG_USER_16_19   = 3'd4,
		REG_PASS_0_7     = 3'd5,
		REG_PASS_8_15    = 3'd6,
		REG_PASS_16_19   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_ADDR  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_VERSION   = 3'd0,
		ERR_NAME_LEN  = 3'd1,
		ERR_PASS_LEN  = 3'd2,
		ERR_MISMATCH  = 3'd3,
		ERR_COMMAND   = 3'd4,
		ERR_ADDR_TYPE = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		AT_IPV4   = 2'd0,
		AT_DOMAIN = 2'd1,
		AT_IPV6   = 2'd2
	} atype_t;

	typedef enum logic [3:0] {
		PH_G_VER   = 4'd0,
		PH_G_NMETH = 4'd1,
		PH_G_METH  = 4'd2,
		PH_A_VER   = 4'd3,
		PH_A_ULEN  = 4'd4,
		PH_A_UNAME = 4'd5,
		PH_A_PLEN  = 4'd6,
		PH_A_PASS  = 4'd7,
		PH_R_VER   = 4'd8,
		PH_R_CMD   = 4'd9,
		PH_R_RSV   = 4'd10,
		PH_R_ATYP  = 4'd11,
		PH_R_DLEN  = 4'd12,
		PH_R_ADDR  = 4'd13,
		PH_R_PORT  = 4'd14,
		PH_HALT    = 4'd15
	} phase_t;

	// One result word
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		atype_t      dest_atype;
		logic [15:0] dest_port;
		err_t        error_code;
		logic        last;
	} res_t;

	// Results of one parsed byte
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} emit_t;

	// Configuration registers
	typedef struct packed {
		logic [4:0]                      user_len;
		logic [4:0]                      pass_len;
		logic [CRED_BYTES-1:0][7:0]      user_chars;
		logic [CRED_BYTES-1:0][7:0]      pass_chars;
	} cfg_t;

	function automatic res_t reply_res(input logic [7:0] b, input logic last);
		res_t r;
		r = '0;
		r.kind = KIND_REPLY;
		r.out_byte = b;
		r.last = last;
		return r;
	endfunction

	function automatic res_t err_res(input err_t code);
		res_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.error_code = code;
		r.last = 1'b1;
		return r;
	endfunction

	// Configured byte at idx, zero past the stored bytes
	function automatic logic [7:0] cred_byte(input logic [CRED_BYTES-1:0][7:0] chars,
			input logic [7:0] idx);
		logic [7:0] b;
		b = 8'd0;
		if (idx < 8'(CRED_BYTES)) begin
			b = chars[idx[CRED_IDX_W-1:0]];
		end
		return b;
	endfunction

endpackage

@@ rtl/core/s5hp_parse.sv @@
module s5hp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              func,
	input  logic [7:0]        in_byte,
	input  s5hp_pkg::cfg_t    cfg,
	output s5hp_pkg::emit_t   emit
);

	`include "socks5_handshake_parser_macros.svh"

	s5hp_pkg::phase_t phase_q, phase_d;
	logic [7:0]       byte_count_q, byte_count_d;
	logic [7:0]       field_length_q, field_length_d;
	logic             creds_match_q, creds_match_d;
	s5hp_pkg::atype_t addr_kind_q, addr_kind_d;
	logic [7:0]       port_high_q, port_high_d;
	logic [7:0]       sub_version_q, sub_version_d;

	logic       auth_on;
	logic [7:0] cnt_inc;
	logic       m;
	s5hp_pkg::res_t done_r;

	assign auth_on = (cfg.user_len != 5'd0) && (cfg.pass_len != 5'd0);
	assign cnt_inc = byte_count_q + 8'd1;

	always_comb begin
		done_r = '0;
		done_r.kind = s5hp_pkg::KIND_DONE;
		done_r.dest_atype = addr_kind_q;
		done_r.dest_port = {port_high_q, in_byte};
		done_r.last = 1'b1;
	end

	// Next state and results for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		byte_count_d = byte_count_q;
		field_length_d = field_length_q;
		creds_match_d = creds_match_q;
		addr_kind_d = addr_kind_q;
		port_high_d = port_high_q;
		sub_version_d = sub_version_q;
		emit = '0;
		m = creds_match_q;
		if (func) begin
			phase_d = s5hp_pkg::PH_G_VER;
			byte_count_d = 8'd0;
			field_length_d = 8'd0;
			creds_match_d = 1'b1;
			addr_kind_d = s5hp_pkg::AT_IPV4;
			port_high_d = 8'd0;
			sub_version_d = 8'd0;
		end else begin
			case (phase_q)
				s5hp_pkg::PH_G_VER: begin
					if (in_byte != s5hp_pkg::SOCKS_VER) begin
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_VERSION);
					end else begin
						phase_d = s5hp_pkg::PH_G_NMETH;
					end
				end
				s5hp_pkg::PH_G_NMETH, s5hp_pkg::PH_G_METH: begin
					if (phase_q == s5hp_pkg::PH_G_NMETH) begin
						field_length_d = in_byte;
						byte_count_d = 8'd0;
						phase_d = s5hp_pkg::PH_G_METH;
					end else begin
						byte_count_d = cnt_inc;
					end
					if ((phase_q == s5hp_pkg::PH_G_NMETH && in_byte == 8'd0) ||
						(phase_q == s5hp_pkg::PH_G_METH && cnt_inc >= field_length_q)) begin
						emit.n = 2'd2;
						emit.r0 = s5hp_pkg::reply_res(s5hp_pkg::SOCKS_VER, 1'b0);
						emit.r1 = s5hp_pkg::reply_res(auth_on ? s5hp_pkg::METH_USERPASS :
							s5hp_pkg::METH_NONE, 1'b1);
						phase_d = auth_on ? s5hp_pkg::PH_A_VER : s5hp_pkg::PH_R_VER;
						byte_count_d = 8'd0;
					end
				end
				s5hp_pkg::PH_A_VER: begin
					sub_version_d = in_byte;
					phase_d = s5hp_pkg::PH_A_ULEN;
				end
				s5hp_pkg::PH_A_ULEN: begin
					if (in_byte > s5hp_pkg::MAX_NAME_LEN) begin
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_NAME_LEN);
					end else begin
						field_length_d = in_byte;
						byte_count_d = 8'd0;
						creds_match_d = (in_byte == {3'd0, cfg.user_len});
						phase_d = (in_byte == 8'd0) ? s5hp_pkg::PH_A_PLEN :
							s5hp_pkg::PH_A_UNAME;
					end
				end
				s5hp_pkg::PH_A_UNAME: begin
					if (in_byte != s5hp_pkg::cred_byte(cfg.user_chars, byte_count_q)) begin
						creds_match_d = 1'b0;
					end
					byte_count_d = cnt_inc;
					if (cnt_inc >= field_length_q) begin
						phase_d = s5hp_pkg::PH_A_PLEN;
					end
				end
				s5hp_pkg::PH_A_PLEN, s5hp_pkg::PH_A_PASS: begin
					if (phase_q == s5hp_pkg::PH_A_PLEN) begin
						m = creds_match_q && (in_byte == {3'd0, cfg.pass_len});
						field_length_d = in_byte;
						byte_count_d = 8'd0;
						phase_d = s5hp_pkg::PH_A_PASS;
					end else begin
						m = creds_match_q &&
							(in_byte == s5hp_pkg::cred_byte(cfg.pass_chars, byte_count_q));
						byte_count_d = cnt_inc;
					end
					creds_match_d = m;
					if (phase_q == s5hp_pkg::PH_A_PLEN && in_byte > s5hp_pkg::MAX_PASS_LEN) begin
						// Oversized password length: nothing else changes
						creds_match_d = creds_match_q;
						field_length_d = field_length_q;
						byte_count_d = byte_count_q;
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_PASS_LEN);
					end else if ((phase_q == s5hp_pkg::PH_A_PLEN && in_byte == 8'd0) ||
						(phase_q == s5hp_pkg::PH_A_PASS && cnt_inc >= field_length_q)) begin
						if (!m) begin
							phase_d = s5hp_pkg::PH_HALT;
							emit.n = 2'd1;
							emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_MISMATCH);
						end else begin
							emit.n = 2'd2;
							emit.r0 = s5hp_pkg::reply_res(sub_version_q, 1'b0);
							emit.r1 = s5hp_pkg::reply_res(s5hp_pkg::AUTH_OK, 1'b1);
							phase_d = s5hp_pkg::PH_R_VER;
							byte_count_d = 8'd0;
						end
					end
				end
				s5hp_pkg::PH_R_VER: begin
					if (in_byte != s5hp_pkg::SOCKS_VER) begin
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_VERSION);
					end else begin
						phase_d = s5hp_pkg::PH_R_CMD;
					end
				end
				s5hp_pkg::PH_R_CMD: begin
					if (in_byte != s5hp_pkg::CMD_CONNECT) begin
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_COMMAND);
					end else begin
						phase_d = s5hp_pkg::PH_R_RSV;
					end
				end
				s5hp_pkg::PH_R_RSV: begin
					phase_d = s5hp_pkg::PH_R_ATYP;
				end
				s5hp_pkg::PH_R_ATYP: begin
					byte_count_d = 8'd0;
					if (in_byte == s5hp_pkg::ATYP_IPV4) begin
						addr_kind_d = s5hp_pkg::AT_IPV4;
						field_length_d = s5hp_pkg::IPV4_LEN;
						phase_d = s5hp_pkg::PH_R_ADDR;
					end else if (in_byte == s5hp_pkg::ATYP_IPV6) begin
						addr_kind_d = s5hp_pkg::AT_IPV6;
						field_length_d = s5hp_pkg::IPV6_LEN;
						phase_d = s5hp_pkg::PH_R_ADDR;
					end else if (in_byte == s5hp_pkg::ATYP_DOMAIN) begin
						addr_kind_d = s5hp_pkg::AT_DOMAIN;
						phase_d = s5hp_pkg::PH_R_DLEN;
					end else begin
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = s5hp_pkg::err_res(s5hp_pkg::ERR_ADDR_TYPE);
					end
				end
				s5hp_pkg::PH_R_DLEN: begin
					field_length_d = in_byte;
					byte_count_d = 8'd0;
					phase_d = (in_byte == 8'd0) ? s5hp_pkg::PH_R_PORT : s5hp_pkg::PH_R_ADDR;
				end
				s5hp_pkg::PH_R_ADDR: begin
					emit.n = 2'd1;
					emit.r0 = '0;
					emit.r0.kind = s5hp_pkg::KIND_ADDR;
					emit.r0.out_byte = in_byte;
					emit.r0.dest_atype = addr_kind_q;
					emit.r0.last = 1'b1;
					byte_count_d = cnt_inc;
					if (cnt_inc >= field_length_q) begin
						byte_count_d = 8'd0;
						phase_d = s5hp_pkg::PH_R_PORT;
					end
				end
				s5hp_pkg::PH_R_PORT: begin
					if (byte_count_q == 8'd0) begin
						port_high_d = in_byte;
						byte_count_d = 8'd1;
					end else begin
						byte_count_d = 8'd0;
						phase_d = s5hp_pkg::PH_HALT;
						emit.n = 2'd1;
						emit.r0 = done_r;
					end
				end
				s5hp_pkg::PH_HALT: begin
					phase_d = s5hp_pkg::PH_HALT;
				end
				default: begin
					phase_d = s5hp_pkg::PH_HALT;
				end
			endcase
		end
	end

	// Advance the parse state on each parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= s5hp_pkg::PH_G_VER;
			byte_count_q <= 8'd0;
			field_length_q <= 8'd0;
			creds_match_q <= 1'b1;
			addr_kind_q <= s5hp_pkg::AT_IPV4;
			port_high_q <= 8'd0;
			sub_version_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			byte_count_q <= byte_count_d;
			field_length_q <= field_length_d;
			creds_match_q <= creds_match_d;
			addr_kind_q <= addr_kind_d;
			port_high_q <= port_high_d;
			sub_version_q <= sub_version_d;
		end
	end

	`S5HP_ASSERT_NXT(a_err_halts, fire && emit.n != 2'd0 && emit.r0.kind == s5hp_pkg::KIND_ERR, phase_q == s5hp_pkg::PH_HALT, "error word did not halt parsing")
	`S5HP_ASSERT_IMP(a_halt_silent, fire && phase_q == s5hp_pkg::PH_HALT, emit.n == 2'd0, "halted parser produced a word")

endmodule

@@ rtl/core/s5hp_outq.sv @@
module s5hp_outq #(
	parameter int DEPTH = s5hp_pkg::OUTQ_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  s5hp_pkg::emit_t emit,
	input  logic            push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output s5hp_pkg::res_t  head
);

	`include "socks5_handshake_parser_macros.svh"

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	s5hp_pkg::res_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_n;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	assign push_n = push ? emit.n : 2'd0;
	assign pop = out_valid && out_ready;
	assign wr_ptr_1 = ptr_next(wr_ptr_q);
	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign room = (count_q <= CNT_W'(DEPTH - 2));

	// Hold result words until the consumer takes them
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= emit.r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_1] <= emit.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr_1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= ptr_next(wr_ptr_1);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	`S5HP_ASSERT_IMP(a_no_overflow, push_n != 2'd0, (count_q + CNT_W'(push_n)) <= CNT_W'(DEPTH), "result queue overflow")
	`S5HP_ASSERT_NXT(a_count_hold, push_n == 2'd0 && !pop, count_q == $past(count_q), "queue count moved while idle")

endmodule

@@ rtl/core/socks5_handshake_parser.sv @@
// SOCKS5 server handshake parser: takes one client byte per cycle, when in_ready
// is high, on the in_* channel (func high restarts the session at the greeting) and
// returns reply bytes, destination address bytes, a request-complete word with port
// and address type, or an error word on the out_* channel, one word per cycle while
// out_ready is high. An accepted byte is registered, parsed once the result queue has
// room for its words, and its words land in that small queue, which drives the out_*
// ports. Input is taken every cycle while the queue has room for two words;
// greeting and authentication replies are two words long, so a consumer that
// takes one word per cycle sets the sustained rate. Configuration writes are
// applied on the cycle cfg_wen is high and must be made while idle.
module socks5_handshake_parser #(
	parameter int OUTQ_DEPTH = s5hp_pkg::OUTQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  dest_atype,
	output logic [15:0] dest_port,
	output logic [2:0]  error_code,
	output logic        last
);

	s5hp_pkg::cfg_t  cfg_q;
	s5hp_pkg::emit_t emit;
	s5hp_pkg::res_t  head;
	logic            valid_s1;
	logic            func_s1;
	logic [7:0]      in_byte_s1;
	logic            room;
	logic            fire;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (s5hp_pkg::reg_idx_t'(cfg_idx))
				s5hp_pkg::REG_USER_LEN:   cfg_q.user_len <= cfg_wdata[4:0];
				s5hp_pkg::REG_PASS_LEN:   cfg_q.pass_len <= cfg_wdata[4:0];
				s5hp_pkg::REG_USER_0_7:   cfg_q.user_chars[7:0] <= cfg_wdata;
				s5hp_pkg::REG_USER_8_15:  cfg_q.user_chars[15:8] <= cfg_wdata;
				s5hp_pkg::REG_USER_16_19: cfg_q.user_chars[19:16] <= cfg_wdata[31:0];
				s5hp_pkg::REG_PASS_0_7:   cfg_q.pass_chars[7:0] <= cfg_wdata;
				s5hp_pkg::REG_PASS_8_15:  cfg_q.pass_chars[15:8] <= cfg_wdata;
				s5hp_pkg::REG_PASS_16_19: cfg_q.pass_chars[19:16] <= cfg_wdata[31:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register: parse when the queue can take two words
	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			in_byte_s1 <= in_byte;
		end
	end

	s5hp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.func    (func_s1),
		.in_byte (in_byte_s1),
		.cfg     (cfg_q),
		.emit    (emit)
	);

	s5hp_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.push      (fire),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// Drive the result word fields
	assign kind = head.kind;
	assign out_byte = head.out_byte;
	assign dest_atype = head.dest_atype;
	assign dest_port = head.dest_port;
	assign error_code = head.error_code;
	assign last = head.last;

endmodule

@@ bench/tb_socks5_handshake_parser.sv @@
`timescale 1ns / 100ps

import s5hp_pkg::*;

// Predicts reply, address, completion and error words per client byte and
// checks the words that leave the parser in order.
class handshake_scoreboard;
	res_t        expected_words[$];
	int          mismatches;
	int          kind_seen[4];
	logic [63:0] regs[8];

	phase_t      phase;
	logic [7:0]  count;
	logic [7:0]  field_len;
	logic        creds_ok;
	atype_t      akind;
	logic [7:0]  port_hi;
	logic [7:0]  sub_ver;

	function new();
		foreach (regs[i]) regs[i] = '0;
		mismatches = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
		restart();
	endfunction

	function void restart();
		phase = PH_G_VER;
		count = '0;
		field_len = '0;
		creds_ok = 1'b1;
		akind = AT_IPV4;
		port_hi = '0;
		sub_ver = '0;
	endfunction

	// Keep only the bits each register holds
	function void store_cfg(reg_idx_t idx, logic [63:0] value);
		case (idx)
			REG_USER_LEN, REG_PASS_LEN: begin
				regs[idx] = value & 64'h1F;
			end
			REG_USER_16_19, REG_PASS_16_19: begin
				regs[idx] = value & 64'hFFFF_FFFF;
			end
			default: begin
				regs[idx] = value;
			end
		endcase
	endfunction

	function bit auth_on();
		return regs[REG_USER_LEN] != 0 && regs[REG_PASS_LEN] != 0;
	endfunction

	// Configured credential byte; bytes past the stored twenty read as zero
	function logic [7:0] cred(int base, logic [7:0] idx);
		logic [63:0] w;
		if (idx < 8) begin
			w = regs[base];
		end else if (idx < 16) begin
			w = regs[base + 1];
		end else if (idx < 20) begin
			w = regs[base + 2];
		end else begin
			return 8'h00;
		end
		return w[8 * idx[2:0] +: 8];
	endfunction

	function void push_word(kind_t k, logic [7:0] b, atype_t at, logic [15:0] port,
			err_t ec, logic lst);
		res_t r;
		r = '0;
		r.kind = k;
		r.out_byte = b;
		r.dest_atype = at;
		r.dest_port = port;
		r.error_code = ec;
		r.last = lst;
		expected_words.push_back(r);
	endfunction

	function void halt_with(err_t ec);
		phase = PH_HALT;
		push_word(KIND_ERR, 8'h00, AT_IPV4, 16'h0, ec, 1'b1);
	endfunction

	function void greet_reply();
		push_word(KIND_REPLY, SOCKS_VER, AT_IPV4, 16'h0, ERR_VERSION, 1'b0);
		push_word(KIND_REPLY, auth_on() ? METH_USERPASS : METH_NONE, AT_IPV4, 16'h0,
			ERR_VERSION, 1'b1);
		phase = auth_on() ? PH_A_VER : PH_R_VER;
		count = '0;
	endfunction

	function void auth_done();
		if (!creds_ok) begin
			halt_with(ERR_MISMATCH);
			return;
		end
		push_word(KIND_REPLY, sub_ver, AT_IPV4, 16'h0, ERR_VERSION, 1'b0);
		push_word(KIND_REPLY, AUTH_OK, AT_IPV4, 16'h0, ERR_VERSION, 1'b1);
		phase = PH_R_VER;
		count = '0;
	endfunction

	// Advance the session by one accepted client word
	function void note_byte(logic f, logic [7:0] b);
		if (f) begin
			restart();
			return;
		end
		case (phase)
			PH_G_VER: begin
				if (b != SOCKS_VER) halt_with(ERR_VERSION);
				else phase = PH_G_NMETH;
			end
			PH_G_NMETH: begin
				field_len = b;
				count = '0;
				if (b == 0) greet_reply();
				else phase = PH_G_METH;
			end
			PH_G_METH: begin
				count++;
				if (count >= field_len) greet_reply();
			end
			PH_A_VER: begin
				sub_ver = b;
				phase = PH_A_ULEN;
			end
			PH_A_ULEN: begin
				if (b > MAX_NAME_LEN) begin
					halt_with(ERR_NAME_LEN);
				end else begin
					field_len = b;
					count = '0;
					creds_ok = (b == regs[REG_USER_LEN]);
					phase = (b == 0) ? PH_A_PLEN : PH_A_UNAME;
				end
			end
			PH_A_UNAME: begin
				if (b != cred(REG_USER_0_7, count)) creds_ok = 1'b0;
				count++;
				if (count >= field_len) phase = PH_A_PLEN;
			end
			PH_A_PLEN: begin
				if (b > MAX_PASS_LEN) begin
					halt_with(ERR_PASS_LEN);
				end else begin
					field_len = b;
					count = '0;
					if (b != regs[REG_PASS_LEN]) creds_ok = 1'b0;
					if (b == 0) auth_done();
					else phase = PH_A_PASS;
				end
			end
			PH_A_PASS: begin
				if (b != cred(REG_PASS_0_7, count)) creds_ok = 1'b0;
				count++;
				if (count >= field_len) auth_done();
			end
			PH_R_VER: begin
				if (b != SOCKS_VER) halt_with(ERR_VERSION);
				else phase = PH_R_CMD;
			end
			PH_R_CMD: begin
				if (b != CMD_CONNECT) halt_with(ERR_COMMAND);
				else phase = PH_R_RSV;
			end
			PH_R_RSV: begin
				phase = PH_R_ATYP;
			end
			PH_R_ATYP: begin
				count = '0;
				if (b == ATYP_IPV4) begin
					akind = AT_IPV4;
					field_len = IPV4_LEN;
					phase = PH_R_ADDR;
				end else if (b == ATYP_IPV6) begin
					akind = AT_IPV6;
					field_len = IPV6_LEN;
					phase = PH_R_ADDR;
				end else if (b == ATYP_DOMAIN) begin
					akind = AT_DOMAIN;
					phase = PH_R_DLEN;
				end else begin
					halt_with(ERR_ADDR_TYPE);
				end
			end
			PH_R_DLEN: begin
				field_len = b;
				count = '0;
				phase = (b == 0) ? PH_R_PORT : PH_R_ADDR;
			end
			PH_R_ADDR: begin
				push_word(KIND_ADDR, b, akind, 16'h0, ERR_VERSION, 1'b1);
				count++;
				if (count >= field_len) begin
					count = '0;
					phase = PH_R_PORT;
				end
			end
			PH_R_PORT: begin
				if (count == 0) begin
					port_hi = b;
					count = 8'd1;
				end else begin
					count = '0;
					phase = PH_HALT;
					push_word(KIND_DONE, 8'h00, akind, {port_hi, b}, ERR_VERSION, 1'b1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function void report_field(string name, logic [15:0] want, logic [15:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// Compare one output word with the oldest prediction
	function void check_word(res_t got);
		res_t e;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word kind %0h byte %0h, expected nothing",
				$time, got.kind, got.out_byte);
			mismatches++;
			return;
		end
		e = expected_words.pop_front();
		kind_seen[e.kind]++;
		report_field("kind", e.kind, got.kind);
		report_field("out_byte", e.out_byte, got.out_byte);
		report_field("dest_atype", e.dest_atype, got.dest_atype);
		report_field("dest_port", e.dest_port, got.dest_port);
		report_field("error_code", e.error_code, got.error_code);
		report_field("last", e.last, got.last);
	endfunction
endclass

module tb_socks5_handshake_parser;

	localparam int          HOLD_CYCLES  = 200;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int          SETTLE       = 8;
	localparam int          TARGET_ITEMS = 1500;
	localparam int          PHASES       = 8;

	localparam logic FN_BYTE    = 1'b0;
	localparam logic FN_RESTART = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_idx = REG_USER_LEN;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = FN_BYTE;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [1:0]  dest_atype;
	logic [15:0] dest_port;
	logic [2:0]  error_code;
	logic        last;

	handshake_scoreboard sb = new();

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          items_sent = 0;
	int          sessions = 0;
	int          settings_used = 0;
	int unsigned cycle_count = 0;

	socks5_handshake_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.dest_atype (dest_atype),
		.dest_port  (dest_port),
		.error_code (error_code),
		.last       (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check every word taken from the parser
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word({kind, out_byte, dest_atype, dest_port, error_code, last});
	end

	// Drive out_ready: random stalls, or a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one word and hold it until accepted
	task automatic send_item(logic f, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(f, b);
		items_sent++;
	endtask

	task automatic send_bytes(logic [7:0] bs[$]);
		foreach (bs[i]) send_item(FN_BYTE, bs[i]);
	endtask

	// Stop offering and wait for every predicted word, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(reg_idx_t idx, logic [63:0] v);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.store_cfg(idx, v);
	endtask

	// Write all registers; unused upper bits carry junk to test masking
	task automatic load_creds(logic [4:0] ulen, logic [4:0] plen, logic [159:0] uc,
			logic [159:0] pc);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_cfg(REG_USER_LEN, {junk[63:5], ulen});
		write_cfg(REG_PASS_LEN, {junk[58:0], plen});
		write_cfg(REG_USER_0_7, uc[63:0]);
		write_cfg(REG_USER_8_15, uc[127:64]);
		write_cfg(REG_USER_16_19, {junk[31:0], uc[159:128]});
		write_cfg(REG_PASS_0_7, pc[63:0]);
		write_cfg(REG_PASS_8_15, pc[127:64]);
		write_cfg(REG_PASS_16_19, {junk[63:32], pc[159:128]});
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	// Append a length and credential bytes; zero when the length is over the limit
	function automatic bit add_cred(ref logic [8:0] seq[$], input int base,
			input logic [4:0] cfg_len, input logic [7:0] limit);
		logic [7:0] len;
		logic [7:0] b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 80) len = 8'(cfg_len);
		else if (pick < 90) len = 8'($urandom_range(0, 20));
		else len = 8'($urandom_range(21, 255));
		seq.push_back({FN_BYTE, len});
		if (len > limit) return 1'b0;
		for (int i = 0; i < len; i++) begin
			b = sb.cred(base, 8'(i));
			if ($urandom_range(99) == 0) b ^= 8'($urandom_range(1, 255));
			seq.push_back({FN_BYTE, b});
		end
		return 1'b1;
	endfunction

	// One client session: mostly well formed, sometimes corrupted, cut or noisy
	task automatic run_session();
		logic [8:0] seq[$];
		logic [7:0] n;
		logic [7:0] atyp;
		int pick;
		int cut;
		bit ok;
		seq.push_back({FN_RESTART, 8'($urandom)});
		pick = $urandom_range(99);
		if (pick < 5) begin
			repeat ($urandom_range(1, 6)) seq.push_back({FN_BYTE, 8'($urandom)});
		end else begin
			seq.push_back({FN_BYTE, ($urandom_range(99) < 4) ? 8'($urandom) : SOCKS_VER});
			n = ($urandom_range(39) == 0) ? 8'($urandom_range(4, 255))
				: 8'($urandom_range(0, 3));
			seq.push_back({FN_BYTE, n});
			repeat (n) seq.push_back({FN_BYTE, 8'($urandom)});
			ok = 1'b1;
			if (sb.auth_on()) begin
				seq.push_back({FN_BYTE, 8'($urandom)});
				ok = add_cred(seq, REG_USER_0_7, sb.regs[REG_USER_LEN][4:0], MAX_NAME_LEN)
					&& add_cred(seq, REG_PASS_0_7, sb.regs[REG_PASS_LEN][4:0], MAX_PASS_LEN);
			end
			if (ok) begin
				seq.push_back({FN_BYTE, ($urandom_range(99) < 4) ? 8'($urandom) : SOCKS_VER});
				seq.push_back({FN_BYTE,
					($urandom_range(99) < 4) ? 8'($urandom) : CMD_CONNECT});
				seq.push_back({FN_BYTE, 8'($urandom)});
				pick = $urandom_range(99);
				if (pick < 30) atyp = ATYP_IPV4;
				else if (pick < 60) atyp = ATYP_IPV6;
				else if (pick < 95) atyp = ATYP_DOMAIN;
				else atyp = 8'($urandom);
				seq.push_back({FN_BYTE, atyp});
				if (atyp == ATYP_IPV4) begin
					repeat (IPV4_LEN) seq.push_back({FN_BYTE, 8'($urandom)});
				end else if (atyp == ATYP_IPV6) begin
					repeat (IPV6_LEN) seq.push_back({FN_BYTE, 8'($urandom)});
				end else if (atyp == ATYP_DOMAIN) begin
					n = ($urandom_range(29) == 0) ? 8'($urandom_range(13, 255))
						: 8'($urandom_range(0, 12));
					seq.push_back({FN_BYTE, n});
					repeat (n) seq.push_back({FN_BYTE, 8'($urandom)});
				end
				repeat (2) seq.push_back({FN_BYTE, 8'($urandom)});
			end
		end
		// Truncate some sessions and pad some with extra bytes, which a halted parser drops
		if ($urandom_range(99) < 8) begin
			cut = $urandom_range(1, seq.size());
			while (seq.size() > cut) void'(seq.pop_back());
		end
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 3)) seq.push_back({FN_BYTE, 8'($urandom)});
		foreach (seq[i]) send_item(seq[i][8], seq[i][7:0]);
		sessions++;
	endtask

	initial begin
		int start;
		int phase_sessions;
		logic [7:0] dir[$];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad version after reset, zero methods, empty domain with
		// extreme port, ignored byte after completion, bad command
		send_item(FN_BYTE, 8'h00);
		send_item(FN_RESTART, 8'hFF);
		dir = '{SOCKS_VER, 8'h00, SOCKS_VER, CMD_CONNECT, 8'hFF, ATYP_DOMAIN, 8'h00,
			8'hFF, 8'hFF, 8'hAA};
		send_bytes(dir);
		send_item(FN_RESTART, 8'h00);
		dir = '{SOCKS_VER, 8'h01, 8'h80, SOCKS_VER, 8'h07};
		send_bytes(dir);
		drain();

		// Directed: auth offered, name length over the limit
		load_creds(5'd1, 5'd1, 160'h75, 160'h70);
		send_item(FN_RESTART, 8'h5A);
		dir = '{SOCKS_VER, 8'h00, 8'hFF, 8'd21};
		send_bytes(dir);
		drain();

		// Random phases, each with its own credentials and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			case (p % 6)
				0: load_creds(5'd0, 5'd0, '0, '0);
				1: load_creds(5'd20, 5'd20, '1, '1);
				2: load_creds(5'd1, 5'd1, {5{$urandom}}, {5{$urandom}});
				3: load_creds(5'($urandom_range(1, 20)), 5'($urandom_range(1, 20)),
					{$urandom, $urandom, $urandom, $urandom, $urandom},
					{$urandom, $urandom, $urandom, $urandom, $urandom});
				4: load_creds(5'($urandom_range(21, 31)), 5'($urandom_range(1, 20)),
					{$urandom, $urandom, $urandom, $urandom, $urandom},
					{$urandom, $urandom, $urandom, $urandom, $urandom});
				default: load_creds(5'($urandom_range(1, 20)), 5'd0,
					{$urandom, $urandom, $urandom, $urandom, $urandom},
					{$urandom, $urandom, $urandom, $urandom, $urandom});
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			start = items_sent;
			phase_sessions = 0;
			while (items_sent - start < TARGET_ITEMS / PHASES) begin
				// Back up the output once, and once pause until all words are out
				if (p == 0 && phase_sessions == 2) hold_req = 1'b1;
				if (p == 0 && phase_sessions == 12) drain();
				run_session();
				phase_sessions++;
			end
			drain();
		end

		$display("Covered %0d client bytes in %0d sessions across %0d credential settings.",
			items_sent, sessions, settings_used);
		$display("Words checked: %0d replies, %0d address bytes, %0d completions, %0d errors.",
			sb.kind_seen[KIND_REPLY], sb.kind_seen[KIND_ADDR], sb.kind_seen[KIND_DONE],
			sb.kind_seen[KIND_ERR]);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
